@@ hw/rtl/mctt_pkg.sv @@
// mctt_pkg: shared types, constants and helpers for the edge timestamper.
// No dependencies; compiled first.
`default_nettype none

package mctt_pkg;

   localparam int MCTT_MAX_CHANNELS = 64;   // default lane-covered channel count
   localparam int MCTT_INDEX_BITS   = 48;   // default sample counter width
   localparam int MCTT_QUEUE_DEPTH  = 4;    // pending-beat queue entries (power of two)

   localparam int LANE_BITS  = 8;           // channels scanned by one lane
   localparam int LANE_POS_W = 3;           // position inside a lane
   localparam int SAMPLE_W   = 64;
   localparam int CHAN_W     = 6;
   localparam int IDX_W      = 48;
   localparam int CFG_W      = 7;

   typedef enum logic {
      EV_INIT = 1'b0,
      EV_EDGE = 1'b1
   } mctt_kind_type;

   // One queued input that still owes rsp beats.
   typedef struct packed {
      mctt_kind_type       kind;
      logic [IDX_W-1:0]    index;
      logic [SAMPLE_W-1:0] levels;
      logic [SAMPLE_W-1:0] mask;     // channels still to report (edge entries)
   } mctt_entry_type;

   // What one lane found in its group of channels.
   typedef struct packed {
      logic                  any;
      logic [LANE_POS_W-1:0] pos;
   } mctt_hit_type;

   // Result of merging all lanes.
   typedef struct packed {
      logic              found;
      logic [CHAN_W-1:0] chan;
   } mctt_pick_type;

   // Enabled-channel mask for a channel count, limited to max_ch.
   function automatic logic [SAMPLE_W-1:0] enable_mask(input logic [CFG_W-1:0] count,
                                                       input int max_ch);
      logic [SAMPLE_W-1:0] m;
      m = '0;
      for (int k = 0; k < SAMPLE_W; k++) begin
         m[k] = (k < max_ch) && (CFG_W'(k) < count);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mctt_if.sv @@
// mctt_req_if / mctt_rsp_if: valid/ready channels of the edge timestamper.
// Depends on mctt_pkg for field widths.
`default_nettype none

interface mctt_req_if import mctt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_bits;
   logic                start_capture;

   modport source (output valid, sample_bits, start_capture, input ready);
   modport sink   (input valid, sample_bits, start_capture, output ready);
endinterface

interface mctt_rsp_if import mctt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                event_kind;
   logic [CHAN_W-1:0]   channel;
   logic [IDX_W-1:0]    sample_index;
   logic [SAMPLE_W-1:0] initial_levels;
   logic                last_event;

   modport source (output valid, event_kind, channel, sample_index, initial_levels,
                   last_event, input ready);
   modport sink   (input valid, event_kind, channel, sample_index, initial_levels,
                   last_event, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mctt_lane.sv @@
// mctt_lane: finds the lowest pending channel in one group of channels.
// Depends on mctt_pkg.
`default_nettype none

module mctt_lane import mctt_pkg::*; (
   input  logic [LANE_BITS-1:0] bits,
   output mctt_hit_type         hit
);

   always_comb begin
      hit = '0;
      for (int k = LANE_BITS - 1; k >= 0; k--) begin
         if (bits[k]) begin
            hit.any = 1'b1;
            hit.pos = LANE_POS_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/mctt_merge.sv @@
// mctt_merge: combines lane hits into the lowest pending channel number.
// Depends on mctt_pkg.
`default_nettype none

module mctt_merge import mctt_pkg::*; #(
   parameter int LANES = MCTT_MAX_CHANNELS / LANE_BITS
) (
   input  mctt_hit_type  hits [LANES],
   output mctt_pick_type pick
);

   always_comb begin
      pick = '0;
      for (int l = LANES - 1; l >= 0; l--) begin
         if (hits[l].any) begin
            pick.found = 1'b1;
            pick.chan  = CHAN_W'(l * LANE_BITS) + CHAN_W'(hits[l].pos);
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/mctt_queue.sv @@
// mctt_queue: small FIFO of inputs that still owe rsp beats.
// Depends on mctt_pkg for the entry type.
`default_nettype none

module mctt_queue import mctt_pkg::*; #(
   parameter int DEPTH = MCTT_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mctt_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output mctt_entry_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mctt_entry_type    store [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/multichannel_edge_timestamper_top.sv @@
// multichannel_edge_timestamper_top: logic-analyzer edge timestamper.
// Depends on mctt_pkg, mctt_if, mctt_lane, mctt_merge, mctt_queue.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------------------
//   req     | in  | valid/ready        | sample_bits, start_capture
//   rsp     | out | valid/ready        | event_kind, channel, sample_index,
//           |     |                    | initial_levels, last_event
//   csr     | in  | csr_wr_en (no ack) | channel_count (7 bits)
//
// A req beat updates the counter/previous-sample state in the cycle it is accepted;
// beats with something to report enter a 4-entry queue, then the current-entry register.
// Unless rsp stalls, the emitter sends one rsp beat per cycle: one for a start, one per
// changed channel for an edge sample, none for quiet; sparse edges run at one beat/cycle.
// req_ready drops only while the queue is full; rsp is a registered output stage.
// Reset (synchronous, active high) clears capture state, queue and rsp valid, enables all.
`default_nettype none

module multichannel_edge_timestamper_top import mctt_pkg::*; #(
   parameter int MAX_CHANNELS = MCTT_MAX_CHANNELS,
   parameter int INDEX_BITS   = MCTT_INDEX_BITS
) (
   input  logic             clock,
   input  logic             reset,
   mctt_req_if.sink         req_chan,
   mctt_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int LANES = (MAX_CHANNELS + LANE_BITS - 1) / LANE_BITS;
   localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;

   // ---------------------------------------------------------------- front end
   logic [SAMPLE_W-1:0]   enable_mask_ff;
   logic [SAMPLE_W-1:0]   prev_sample_ff;
   logic [INDEX_BITS-1:0] counter_ff, counter_in;
   logic                  started_ff;

   logic                  req_take;
   logic                  is_start;
   logic [SAMPLE_W-1:0]   diff;
   logic [63:0]           counter_wide;
   logic                  push;
   mctt_entry_type        push_entry;
   logic                  q_full;
   logic                  q_not_empty;
   logic                  q_pop;
   mctt_entry_type        q_head;

   assign req_chan.ready = !q_full;
   assign req_take       = req_chan.valid && req_chan.ready;

   // No capture yet counts as a start.
   assign is_start = req_chan.start_capture || !started_ff;
   assign diff     = (req_chan.sample_bits ^ prev_sample_ff) & enable_mask_ff;

   always_comb begin
      if (is_start) begin
         counter_in = '0;
      end else if (counter_ff == CNT_MAX) begin
         counter_in = counter_ff;   // saturate
      end else begin
         counter_in = counter_ff + 1'b1;
      end
   end

   assign counter_wide = 64'(counter_in);

   always_comb begin
      push_entry = '0;
      if (is_start) begin
         push_entry.kind   = EV_INIT;
         push_entry.levels = req_chan.sample_bits & enable_mask_ff;
      end else begin
         push_entry.kind  = EV_EDGE;
         push_entry.index = counter_wide[IDX_W-1:0];
         push_entry.mask  = diff;
      end
   end

   assign push = req_take && (is_start || (diff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= enable_mask(CFG_W'(MAX_CHANNELS), MAX_CHANNELS);
         prev_sample_ff <= '0;
         counter_ff     <= '0;
         started_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            enable_mask_ff <= enable_mask(csr_wr_data, MAX_CHANNELS);
         end
         if (req_take) begin
            prev_sample_ff <= req_chan.sample_bits;
            counter_ff     <= counter_in;
            started_ff     <= 1'b1;
         end
      end
   end

   mctt_queue #(
      .DEPTH(MCTT_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // ------------------------------------------------------------- edge lanes
   logic                        cur_valid_ff;
   mctt_entry_type              cur_ff;
   logic [LANES*LANE_BITS-1:0]  lane_mask;
   mctt_hit_type                hits [LANES];
   mctt_pick_type               pick;

   assign lane_mask = (LANES*LANE_BITS)'(cur_ff.mask);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      mctt_lane u_lane (
         .bits (lane_mask[g*LANE_BITS +: LANE_BITS]),
         .hit  (hits[g])
      );
   end

   mctt_merge #(
      .LANES(LANES)
   ) u_merge (
      .hits (hits),
      .pick (pick)
   );

   // ---------------------------------------------------------------- emitter
   logic                out_go;
   logic                emit;
   logic [SAMPLE_W-1:0] rest_mask;
   logic                edge_last;
   logic                cur_done;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [SAMPLE_W-1:0] rsp_levels_ff;
   logic                rsp_last_ff;

   assign out_go    = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = out_go && cur_valid_ff;
   assign rest_mask = cur_ff.mask & ~(SAMPLE_W'(1) << pick.chan);
   assign edge_last = (rest_mask == '0);
   assign cur_done  = emit && ((cur_ff.kind == EV_INIT) || edge_last);
   assign q_pop     = q_not_empty && (!cur_valid_ff || cur_done);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end else if (emit) begin
         cur_ff.mask <= rest_mask;
      end
      if (emit) begin
         rsp_kind_ff <= cur_ff.kind;
         if (cur_ff.kind == EV_INIT) begin
            rsp_chan_ff   <= '0;
            rsp_index_ff  <= '0;
            rsp_levels_ff <= cur_ff.levels;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_chan_ff   <= pick.chan;
            rsp_index_ff  <= cur_ff.index;
            rsp_levels_ff <= '0;
            rsp_last_ff   <= edge_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
         end else if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end
         if (out_go) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.event_kind     = rsp_kind_ff;
   assign rsp_chan.channel        = rsp_chan_ff;
   assign rsp_chan.sample_index   = rsp_index_ff;
   assign rsp_chan.initial_levels = rsp_levels_ff;
   assign rsp_chan.last_event     = rsp_last_ff;

endmodule

`default_nettype wire

@@ tb/sv/multichannel_edge_timestamper_top_tb.sv @@
// Self-checking bench for multichannel_edge_timestamper_top: directed and random samples,
// with a model of the edge timestamper that checks every rsp beat in order.
// Depends on mctt_pkg, mctt_if and the block's RTL.

module multichannel_edge_timestamper_top_tb;
   import mctt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
   localparam int LONG_HOLD    = 300;   // rsp back-pressure stretch, fills the queue
   localparam int SETTLE_CYCLS = 24;    // margin for beats still inside the block

   typedef struct {
      logic [SAMPLE_W-1:0] bits;
      logic                start;
   } probe_word_type;

   typedef struct {
      mctt_kind_type       kind;
      logic [CHAN_W-1:0]   chan;
      logic [IDX_W-1:0]    index;
      logic [SAMPLE_W-1:0] levels;
      logic                last;
   } edge_event_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   mctt_req_if req_chan ();
   mctt_rsp_if rsp_chan ();

   multichannel_edge_timestamper_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow state of the timestamper.
   logic [CFG_W-1:0]    chan_count;
   logic [SAMPLE_W-1:0] last_sample;
   logic [IDX_W-1:0]    sample_count;
   logic                capture_live;

   probe_word_type samples_pending[$];
   edge_event_type owed_events[$];
   probe_word_type req_beat;

   int samples_queued;
   int samples_taken;
   int mismatches;
   int gap_left;
   int stall_left;
   int hold_seq;
   int hold_seen;
   int quiet_cycles;
   bit no_idle;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
   endtask

   // Fold one accepted sample into the shadow state and queue the events it owes.
   task automatic timestamp_sample(input probe_word_type w);
      logic [SAMPLE_W-1:0] enabled;
      logic [SAMPLE_W-1:0] diff;
      edge_event_type      ev;
      int                  top_ch;
      int                  k;
      enabled = '0;
      for (k = 0; k < SAMPLE_W; k++)
         enabled[k] = (k < chan_count);
      if (w.start || !capture_live) begin
         // start marked, or the first sample ever: report initial levels
         capture_live = 1'b1;
         sample_count = '0;
         last_sample  = w.bits;
         ev.kind   = EV_INIT;
         ev.chan   = '0;
         ev.index  = '0;
         ev.levels = w.bits & enabled;
         ev.last   = 1'b1;
         owed_events.push_back(ev);
      end else begin
         // saturating counter (2^48 samples is out of reach in simulation)
         if (sample_count != '1)
            sample_count = sample_count + 1'b1;
         diff        = (w.bits ^ last_sample) & enabled;
         last_sample = w.bits;
         top_ch = -1;
         for (k = 0; k < SAMPLE_W; k++)
            if (diff[k])
               top_ch = k;
         for (k = 0; k < SAMPLE_W; k++) begin
            if (diff[k]) begin
               ev.kind   = EV_EDGE;
               ev.chan   = CHAN_W'(k);
               ev.index  = sample_count;
               ev.levels = '0;
               ev.last   = (k == top_ch);
               owed_events.push_back(ev);
            end
         end
      end
   endtask

   task automatic check_event();
      edge_event_type want;
      if (owed_events.size() == 0) begin
         flag_mismatch("unexpected beat, channel", rsp_chan.channel, 0);
      end else begin
         want = owed_events.pop_front();
         if (rsp_chan.event_kind !== want.kind)
            flag_mismatch("event_kind", rsp_chan.event_kind, want.kind);
         if (rsp_chan.channel !== want.chan)
            flag_mismatch("channel", rsp_chan.channel, want.chan);
         if (rsp_chan.sample_index !== want.index)
            flag_mismatch("sample_index", rsp_chan.sample_index, want.index);
         if (rsp_chan.initial_levels !== want.levels)
            flag_mismatch("initial_levels", rsp_chan.initial_levels, want.levels);
         if (rsp_chan.last_event !== want.last)
            flag_mismatch("last_event", rsp_chan.last_event, want.last);
      end
   endtask

   // Driver: predicts on each accepted beat, holds valid until taken, idles in bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            timestamp_sample(req_beat);
            samples_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (!no_idle && samples_pending.size() != 0
                         && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 14) - 1;
               req_chan.valid <= 1'b0;
            end else if (samples_pending.size() != 0) begin
               req_beat = samples_pending.pop_front();
               req_chan.sample_bits   <= req_beat.bits;
               req_chan.start_capture <= req_beat.start;
               req_chan.valid         <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each rsp beat; stalls in bursts, plus one long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_event();
         if (hold_seen != hold_seq) begin
            hold_seen  = hold_seq;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("timeout after %0d quiet cycles, %0d events owed",
               quiet_cycles, owed_events.size());
      $display("== FAIL ==");
      $finish;
   end

   task automatic queue_sample(input logic [SAMPLE_W-1:0] bits, input logic start);
      probe_word_type w;
      w.bits  = bits;
      w.start = start;
      samples_pending.push_back(w);
      samples_queued++;
   endtask

   // Only called while idle.
   task automatic set_channel_count(input logic [CFG_W-1:0] count);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      chan_count = count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      while (samples_taken != samples_queued || owed_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLS) @(posedge clock);
   endtask

   // Mostly sparse toggles on a running word, some restarts, repeats and noise.
   task automatic random_samples(input int n);
      logic [SAMPLE_W-1:0] word;
      int                  r;
      int                  i;
      int                  j;
      word = {$urandom(), $urandom()};
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            word = {$urandom(), $urandom()};
            queue_sample(word, 1'b1);
         end else if (r < 16) begin
            word = {$urandom(), $urandom()};
            queue_sample(word, 1'b0);
         end else if (r < 26) begin
            queue_sample(word, 1'b0);
         end else begin
            for (j = $urandom_range(1, 3); j > 0; j--)
               word[$urandom_range(0, SAMPLE_W - 1)] ^= 1'b1;
            queue_sample(word, 1'b0);
         end
      end
   endtask

   initial begin : run
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_chan.valid = 1'b0;
      req_chan.sample_bits   = '0;
      req_chan.start_capture = 1'b0;
      rsp_chan.ready = 1'b0;
      chan_count     = CFG_W'(MCTT_MAX_CHANNELS);
      last_sample    = '0;
      sample_count   = '0;
      capture_live   = 1'b0;
      samples_queued = 0;
      samples_taken  = 0;
      mismatches     = 0;
      hold_seq       = 0;
      hold_seen      = 0;
      quiet_cycles   = 0;
      no_idle        = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset count (all 64 channels): a non-start first sample acts as a start.
      queue_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      queue_sample(64'h0000_0000_0000_0000, 1'b0);   // all 64 fall
      queue_sample(64'h0000_0000_0000_0000, 1'b0);   // no change, no beat
      queue_sample(64'h8000_0000_0000_0001, 1'b0);   // outermost channels
      queue_sample(64'h8000_0000_0000_0001, 1'b1);   // restart
      queue_sample(64'h5555_5555_5555_5555, 1'b1);   // back-to-back restart
      queue_sample(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_sample(64'hAAAA_AAAA_AAAA_AAAB, 1'b0);
      settle();

      // One channel: upper bits are ignored.
      set_channel_count(7'd1);
      queue_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      queue_sample(64'h0000_0000_0000_0001, 1'b0);
      queue_sample(64'h0000_0000_0000_0000, 1'b0);
      settle();

      // No channel enabled: zero levels, never an edge.
      set_channel_count(7'd0);
      queue_sample(64'hDEAD_BEEF_0123_4567, 1'b1);
      queue_sample(64'h2152_4110_FEDC_BA98, 1'b0);
      queue_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      settle();

      // Count beyond the channel limit behaves as all channels.
      set_channel_count(7'd127);
      queue_sample(64'h0000_0000_0000_0000, 1'b0);
      queue_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      queue_sample(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
      settle();

      set_channel_count(7'd8);
      queue_sample(64'h0000_0000_0000_01FF, 1'b0);
      queue_sample(64'hFFFF_FFFF_FFFF_FF80, 1'b0);
      random_samples(20);
      settle();

      // Long rsp hold while samples keep coming: the queue fills, req stalls.
      set_channel_count(7'd37);
      hold_seq++;
      random_samples(40);
      settle();

      set_channel_count(CFG_W'($urandom_range(1, 63)));
      random_samples(30);
      settle();

      // Closing stretch at full rate on both sides.
      set_channel_count(7'd64);
      no_idle = 1'b1;
      random_samples(40);
      settle();

      if (owed_events.size() != 0)
         flag_mismatch("events never seen", owed_events.size(), 0);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
